// ===== rtl/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdc_pkg: shared constants for the radix digit converter
// Widths, register decode, base limits and ASCII digit codes used by the
// converter's front, back, divider and top level.
// ----------------------------------------------------------------------------
package rdc_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int VALUE_WIDTH_DEF = 31;
  localparam int MAX_DIGITS_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Base register.
  localparam int RADIX_W = 6;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  // Configuration port decode.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_RADIX = 1'b0;

  // Quotient bits retired by the divider in each cycle.
  localparam int DIV_BITS = 4;

  // ASCII digit coding.
  localparam int CHAR_W = 7;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_UPPERA = 7'd65;
  localparam logic [RADIX_W-1:0] DEC_MAX     = 6'd9;
  localparam logic [RADIX_W-1:0] DEC_BASE    = 6'd10;

endpackage

// ===== rtl/rdc_fifo.sv =====
// ----------------------------------------------------------------------------
// rdc_fifo: small synchronous queue
// Holds requests between two parts of the converter; the oldest entry is
// always presented on rdata while empty is low.
// ----------------------------------------------------------------------------
module rdc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== rtl/rdc_front.sv =====
// ----------------------------------------------------------------------------
// rdc_front: request intake
// Registers each incoming number together with the base clamped into the
// legal range, then hands the request to the command queue.
// ----------------------------------------------------------------------------
module rdc_front #(
  parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rdc_pkg::RADIX_W-1:0] radix,
  input  logic                        push,
  input  logic [VALUE_WIDTH-1:0]      number_in,
  output logic                        full,
  output logic                        cmd_push,
  output logic [rdc_pkg::RADIX_W-1:0] cmd_base,
  output logic [VALUE_WIDTH-1:0]      cmd_value,
  input  logic                        cmd_full
);

  logic                        stage_valid;
  logic [rdc_pkg::RADIX_W-1:0] stage_base;
  logic [VALUE_WIDTH-1:0]      stage_value;
  logic [rdc_pkg::RADIX_W-1:0] base_eff;
  logic                        accept;

  // Bases below two act as binary, bases above thirty-six as base 36.
  always_comb begin
    priority if (radix < rdc_pkg::RADIX_MIN) begin
      base_eff = rdc_pkg::RADIX_MIN;
    end else if (radix > rdc_pkg::RADIX_MAX) begin
      base_eff = rdc_pkg::RADIX_MAX;
    end else begin
      base_eff = radix;
    end
  end

  assign full      = stage_valid && cmd_full;
  assign accept    = push && !full;
  assign cmd_push  = stage_valid && !cmd_full;
  assign cmd_base  = stage_base;
  assign cmd_value = stage_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (cmd_push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_base  <= base_eff;
      stage_value <= number_in;
    end
  end

endmodule

// ===== rtl/rdc_divider.sv =====
// ----------------------------------------------------------------------------
// rdc_divider: iterative divider by a small base
// Restoring division that retires DIV_BITS quotient bits per cycle and
// returns the quotient and the remainder with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module rdc_divider #(
  parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [VALUE_WIDTH-1:0]      dividend,
  input  logic [rdc_pkg::RADIX_W-1:0] divisor,
  output logic                        busy,
  output logic                        done,
  output logic [VALUE_WIDTH-1:0]      quotient,
  output logic [rdc_pkg::RADIX_W-1:0] remainder
);

  localparam int STEPS = (VALUE_WIDTH + rdc_pkg::DIV_BITS - 1) / rdc_pkg::DIV_BITS;
  localparam int PAD_W = STEPS * rdc_pkg::DIV_BITS;
  localparam int SW    = $clog2(STEPS + 1);

  logic [PAD_W-1:0]            work;
  logic [PAD_W-1:0]            work_next;
  logic [rdc_pkg::RADIX_W-1:0] rem;
  logic [rdc_pkg::RADIX_W-1:0] rem_next;
  logic [rdc_pkg::RADIX_W-1:0] divisor_q;
  logic [SW-1:0]               step_cnt;

  // The dividend shifts out of the top of work while quotient bits shift
  // in at the bottom, so work holds the full quotient after the last step.
  always_comb begin
    logic [rdc_pkg::RADIX_W-1:0] r_acc;
    logic [rdc_pkg::RADIX_W:0]   r_ext;
    logic [PAD_W-1:0]            w_acc;
    r_acc = rem;
    w_acc = work;
    for (int i = 0; i < rdc_pkg::DIV_BITS; i++) begin
      r_ext = {r_acc, w_acc[PAD_W-1]};
      w_acc = {w_acc[PAD_W-2:0], 1'b0};
      if (r_ext >= {1'b0, divisor_q}) begin
        r_acc    = rdc_pkg::RADIX_W'(r_ext - {1'b0, divisor_q});
        w_acc[0] = 1'b1;
      end else begin
        r_acc = r_ext[rdc_pkg::RADIX_W-1:0];
      end
    end
    rem_next  = r_acc;
    work_next = w_acc;
  end

  assign quotient  = work[VALUE_WIDTH-1:0];
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step_cnt <= SW'(STEPS);
      end else if (busy) begin
        step_cnt <= step_cnt - 1'b1;
        if (step_cnt == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work      <= PAD_W'(dividend);
      rem       <= '0;
      divisor_q <= divisor;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (remainder < divisor_q))
    else $error("divider remainder not below divisor");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider restarted while busy");

endmodule

// ===== rtl/rdc_back.sv =====
// ----------------------------------------------------------------------------
// rdc_back: conversion sequencer
// Takes queued requests, divides repeatedly by the base while stacking the
// remainders, then unstacks them as ASCII digits, most significant first.
// ----------------------------------------------------------------------------
module rdc_back #(
  parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = rdc_pkg::MAX_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_empty,
  input  logic [rdc_pkg::RADIX_W-1:0] cmd_base,
  input  logic [VALUE_WIDTH-1:0]      cmd_value,
  output logic                        cmd_pop,
  output logic                        out_push,
  output logic [rdc_pkg::CHAR_W-1:0]  out_char,
  output logic                        out_last,
  input  logic                        out_full
);

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_PUSH
  } state_t;

  state_t                      state;
  logic [CW-1:0]               cnt;
  logic [rdc_pkg::RADIX_W-1:0] base;
  logic                        div_start;
  logic [VALUE_WIDTH-1:0]      div_dividend;
  logic                        div_busy;
  logic                        div_done;
  logic [VALUE_WIDTH-1:0]      div_quotient;
  logic [rdc_pkg::RADIX_W-1:0] div_remainder;
  logic [rdc_pkg::RADIX_W-1:0] stack [MAX_DIGITS];
  logic [rdc_pkg::RADIX_W-1:0] rd_digit;
  logic [CW-1:0]               cnt_dec;

  function automatic logic [rdc_pkg::CHAR_W-1:0] digit_ascii(
    input logic [rdc_pkg::RADIX_W-1:0] d
  );
    logic [rdc_pkg::CHAR_W-1:0] c;
    if (d <= rdc_pkg::DEC_MAX) begin
      c = rdc_pkg::CHAR_ZERO + rdc_pkg::CHAR_W'(d);
    end else begin
      c = rdc_pkg::CHAR_UPPERA + rdc_pkg::CHAR_W'(d - rdc_pkg::DEC_BASE);
    end
    return c;
  endfunction

  rdc_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (base),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient),
    .remainder(div_remainder)
  );

  assign cmd_pop  = (state == S_IDLE) && !cmd_empty;
  assign out_push = (state == S_PUSH) && !out_full;
  assign out_char = digit_ascii(rd_digit);
  assign out_last = (cnt == CW'(1));
  assign cnt_dec  = cnt - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            base         <= cmd_base;
            div_dividend <= cmd_value;
            div_start    <= 1'b1;
            cnt          <= '0;
            state        <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            cnt <= cnt + 1'b1;
            // Keep dividing while digits remain and the stack has room.
            if ((div_quotient != '0) && (cnt < CW'(MAX_DIGITS - 1))) begin
              div_dividend <= div_quotient;
              div_start    <= 1'b1;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (!out_full) begin
            cnt   <= cnt_dec;
            state <= (cnt == CW'(1)) ? S_IDLE : S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DIV) && div_done) begin
      stack[cnt[AW-1:0]] <= div_remainder;
    end
    if (state == S_READ) begin
      rd_digit <= stack[cnt_dec[AW-1:0]];
    end
  end

  a_done_while_dividing: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide phase");

  a_stack_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (cnt < CW'(MAX_DIGITS)))
    else $error("digit stack index out of range");

  a_busy_while_dividing: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == S_DIV))
    else $error("divider busy outside the divide phase");

endmodule

// ===== rtl/radix_digit_converter.sv =====
// ----------------------------------------------------------------------------
// radix_digit_converter: integer to base-N ASCII digit stream
// Converts each pushed number into its digits in the programmed base and
// delivers them one per result request, most significant digit first.
// ----------------------------------------------------------------------------
// Timing: the first digit of a number appears only after all of its divisions are done;
//   each following digit passes through the S_READ and S_PUSH states of the sequencer.
// The one divider in the back sets the rate at which numbers are converted, and up to
//   three numbers wait in front of it (the front stage and the command queue).
// Reset (rst, synchronous, active high) empties both queues, idles the
//   sequencer and loads radix with 10; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module radix_digit_converter #(
  parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = rdc_pkg::MAX_DIGITS_DEF,
  parameter int QUEUE_DEPTH = rdc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rdc_pkg::PADDR_W-1:0] paddr,
  input  logic [rdc_pkg::PDATA_W-1:0] pwdata,
  output logic [rdc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  // Number requests.
  input  logic                        push,
  output logic                        full,
  input  logic [VALUE_WIDTH-1:0]      number_in,
  // Digit results.
  output logic                        empty,
  input  logic                        pop,
  output logic [rdc_pkg::CHAR_W-1:0]  digit_char,
  output logic                        last_digit
);

  localparam int CMD_W = rdc_pkg::RADIX_W + VALUE_WIDTH;
  localparam int OUT_W = rdc_pkg::CHAR_W + 1;

  logic [rdc_pkg::RADIX_W-1:0] radix;
  logic                        reg_write;
  logic                        radix_sel;

  logic                        cmd_push;
  logic                        cmd_full;
  logic                        cmd_pop;
  logic                        cmd_empty;
  logic [rdc_pkg::RADIX_W-1:0] front_base;
  logic [VALUE_WIDTH-1:0]      front_value;
  logic [CMD_W-1:0]            cmd_rdata;

  logic                        out_push;
  logic                        out_full;
  logic [rdc_pkg::CHAR_W-1:0]  out_char;
  logic                        out_last;
  logic [OUT_W-1:0]            out_rdata;

  // The port never inserts wait states. The base register is the only
  // register; the low address bits inside its word are ignored.
  assign pready    = 1'b1;
  assign radix_sel = (paddr[rdc_pkg::PADDR_W-1] == rdc_pkg::REG_RADIX);
  assign reg_write = psel && penable && pwrite && pready && radix_sel;
  assign prdata    = radix_sel ? rdc_pkg::PDATA_W'(radix) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= rdc_pkg::RADIX_RESET;
    end else if (reg_write) begin
      radix <= pwdata[rdc_pkg::RADIX_W-1:0];
    end
  end

  // Front: takes in each number and resolves the base it converts in.
  rdc_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .radix    (radix),
    .push     (push),
    .number_in(number_in),
    .full     (full),
    .cmd_push (cmd_push),
    .cmd_base (front_base),
    .cmd_value(front_value),
    .cmd_full (cmd_full)
  );

  // Command queue lets the front keep taking numbers while the back works.
  rdc_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_push),
    .wdata({front_base, front_value}),
    .full (cmd_full),
    .pop  (cmd_pop),
    .rdata(cmd_rdata),
    .empty(cmd_empty)
  );

  // Back: repeated division, digit stack and ASCII emission.
  rdc_back #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_empty(cmd_empty),
    .cmd_base (cmd_rdata[CMD_W-1:VALUE_WIDTH]),
    .cmd_value(cmd_rdata[VALUE_WIDTH-1:0]),
    .cmd_pop  (cmd_pop),
    .out_push (out_push),
    .out_char (out_char),
    .out_last (out_last),
    .out_full (out_full)
  );

  // Result queue decouples digit emission from the consumer's pop rate.
  rdc_fifo #(
    .WIDTH(OUT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (out_push),
    .wdata({out_last, out_char}),
    .full (out_full),
    .pop  (pop),
    .rdata(out_rdata),
    .empty(empty)
  );

  assign digit_char = out_rdata[rdc_pkg::CHAR_W-1:0];
  assign last_digit = out_rdata[OUT_W-1];

endmodule

// ===== verif/radix_digit_converter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix_digit_converter_tb: self-checking bench for the radix digit converter
// Numbers go in through the push/full request side. Each accepted number is
// expanded into its ASCII digits here, in the programmed base. Every digit
// popped from the converter is compared field by field against them.
// ----------------------------------------------------------------------------
module radix_digit_converter_tb;

  localparam int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF;
  localparam longint unsigned MAX_VALUE = (64'd1 << VALUE_WIDTH) - 1;
  // Register i of the map sits at byte address 4*i.
  localparam logic [rdc_pkg::PADDR_W-1:0] RADIX_ADDR =
    rdc_pkg::PADDR_W'(int'(rdc_pkg::REG_RADIX) * 4);
  localparam int CHUNK_ITEMS = 13;
  localparam int RANDOM_CHUNKS = 4;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 64;

  // One expected digit of a conversion.
  typedef struct packed {
    logic [rdc_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } digit_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Every input of the converter starts from a known value.
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [rdc_pkg::PADDR_W-1:0] paddr = '0;
  logic [rdc_pkg::PDATA_W-1:0] pwdata = '0;
  logic [rdc_pkg::PDATA_W-1:0] prdata;
  logic                        pready;
  logic                        push = 1'b0;
  logic                        full;
  logic [VALUE_WIDTH-1:0]      number_in = '0;
  logic                        empty;
  logic                        pop = 1'b0;
  logic [rdc_pkg::CHAR_W-1:0]  digit_char;
  logic                        last_digit;

  // Numbers waiting to be offered, and digits waiting to come out.
  logic [VALUE_WIDTH-1:0] pending_numbers[$];
  digit_rec_t             expected_digits[$];

  // Copy of the base register, updated when a write completes.
  logic [rdc_pkg::RADIX_W-1:0] radix_shadow = rdc_pkg::RADIX_RESET;
  logic [63:0]                 radix_seen = 64'd0;

  // Flow control knobs. They are set on the falling edge; the long receiver hold then counts down on the rising edge.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        sender_hold = 1'b0;
  int unsigned recv_hold_left = 0;

  int unsigned error_count = 0;
  int unsigned numbers_sent = 0;
  int unsigned digits_checked = 0;
  int unsigned longest_run = 0;
  int unsigned full_stalls = 0;

  radix_digit_converter dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .push       (push),
    .full       (full),
    .number_in  (number_in),
    .empty      (empty),
    .pop        (pop),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Only the first ten failures are described. Later ones are only counted.
  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  // The register value is saturated into the range of bases that the
  // converter supports: values below two act as base two, and values above
  // thirty-six act as base thirty-six.
  function automatic int unsigned base_of(input logic [rdc_pkg::RADIX_W-1:0] r);
    if (r < rdc_pkg::RADIX_MIN) begin
      return int'(rdc_pkg::RADIX_MIN);
    end
    if (r > rdc_pkg::RADIX_MAX) begin
      return int'(rdc_pkg::RADIX_MAX);
    end
    return int'(r);
  endfunction

  // Converts one accepted number into its digits, most significant first,
  // and queues them. Zero still produces the single digit '0'.
  task automatic queue_digits(input logic [VALUE_WIDTH-1:0] value);
    longint unsigned v;
    int unsigned     base;
    int unsigned     rems[$];
    digit_rec_t      rec;
    base = base_of(radix_shadow);
    v = value;
    do begin
      rems.push_front(int'(v % base));
      v = v / base;
    end while (v != 0);
    foreach (rems[k]) begin
      if (rems[k] <= rdc_pkg::DEC_MAX) begin
        rec.ch = rdc_pkg::CHAR_ZERO + rdc_pkg::CHAR_W'(rems[k]);
      end else begin
        rec.ch = rdc_pkg::CHAR_UPPERA + rdc_pkg::CHAR_W'(rems[k] - rdc_pkg::DEC_BASE);
      end
      rec.last = (k == rems.size() - 1);
      expected_digits.push_back(rec);
    end
    if (rems.size() > longest_run) begin
      longest_run = rems.size();
    end
  endtask

  // Random numbers are spread over several shapes: the full range, small
  // values, values next to a power of the base, and values of random length.
  // The values next to a power of the base change the digit count.
  function automatic logic [VALUE_WIDTH-1:0] pick_number(input int unsigned base);
    longint unsigned p;
    int unsigned     k;
    p = 1;
    case ($urandom_range(3))
      0: return VALUE_WIDTH'($urandom);
      1: return VALUE_WIDTH'($urandom_range(2 * base));
      2: begin
        k = $urandom_range(30);
        while (k > 0 && p * base <= MAX_VALUE) begin
          p = p * base;
          k--;
        end
        return VALUE_WIDTH'(p - $urandom_range(1));
      end
      default: return VALUE_WIDTH'($urandom >> $urandom_range(1, 31));
    endcase
  endfunction

  // Driver. A number stays on the port until it is accepted. A new number is
  // offered only when the port is free and the sender is not idling.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      number_in <= '0;
    end else begin
      if (push && !full) begin
        queue_digits(number_in);
        numbers_sent++;
      end
      if (push && full) begin
        full_stalls++;
      end
      if (!push || !full) begin
        if (!sender_hold && pending_numbers.size() != 0 &&
            $urandom_range(99) >= send_idle_pct) begin
          push <= 1'b1;
          number_in <= pending_numbers.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // The long receiver hold is counted down in its own process.
  always @(posedge clk) begin
    if (recv_hold_left != 0) begin
      recv_hold_left <= recv_hold_left - 1;
    end
  end

  // Monitor. Each accepted digit is compared against the oldest expected digit.
  always @(posedge clk) begin
    digit_rec_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_digits.size() == 0) begin
          flag_error($sformatf("digit '%c' last=%0b arrived with nothing expected",
                               digit_char, last_digit));
        end else begin
          want = expected_digits.pop_front();
          digits_checked++;
          if (digit_char !== want.ch) begin
            flag_error($sformatf("digit_char expected 0x%02h got 0x%02h",
                                 want.ch, digit_char));
          end
          if (last_digit !== want.last) begin
            flag_error($sformatf("last_digit expected %0b got %0b (digit 0x%02h)",
                                 want.last, last_digit, want.ch));
          end
        end
      end
      pop <= (recv_hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Returns once every queued number is accepted and every digit is out.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_numbers.size() != 0 || push || expected_digits.size() != 0);
  endtask

  // Writes the base register while the converter is idle, then reads it back.
  // The upper bits of the write data are random, and the register must drop them.
  task automatic set_radix(input logic [rdc_pkg::RADIX_W-1:0] value);
    logic [rdc_pkg::PDATA_W-1:0] readback;
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RADIX_ADDR;
    pwdata <= rdc_pkg::PDATA_W'({$urandom, value});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    radix_shadow = value;
    radix_seen[value] = 1'b1;
    // A read setup follows straight after the write access.
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== rdc_pkg::PDATA_W'(value)) begin
      flag_error($sformatf("radix readback expected %0d got %0d", value, readback));
    end
  endtask

  // Random part: each chunk uses a fresh base, which is usually a legal one.
  // Sometimes it is any 6-bit value, so that saturation is also covered.
  // One chunk can carry a sender pause or a long receiver hold.
  task automatic run_random(input bit with_sender_pause, input bit with_recv_hold);
    logic [rdc_pkg::RADIX_W-1:0] r;
    for (int c = 0; c < RANDOM_CHUNKS; c++) begin
      if ($urandom_range(5) == 0) begin
        r = rdc_pkg::RADIX_W'($urandom_range(63));
      end else begin
        r = rdc_pkg::RADIX_W'($urandom_range(int'(rdc_pkg::RADIX_MIN),
                                             int'(rdc_pkg::RADIX_MAX)));
      end
      set_radix(r);
      @(negedge clk);
      for (int i = 0; i < CHUNK_ITEMS; i++) begin
        pending_numbers.push_back(pick_number(base_of(r)));
      end
      if (c == 1 && with_sender_pause) begin
        // Part of the chunk goes out. The sender then waits until the last
        // digit is out before it offers the rest.
        while (pending_numbers.size() > CHUNK_ITEMS / 2) @(negedge clk);
        sender_hold = 1'b1;
        do @(negedge clk);
        while (push || expected_digits.size() != 0);
        sender_hold = 1'b0;
      end
      if (c == 1 && with_recv_hold) begin
        // Nothing is popped for a long stretch, while numbers keep coming.
        // The converter fills up and holds full high.
        recv_hold_left = LONG_HOLD;
      end
    end
  endtask

  // Directed part, then the random part in three flow control settings.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    send_idle_pct = 12;
    recv_idle_pct = 67;

    // Reset base of ten: zero, one digit values, decade boundaries and the
    // largest input.
    pending_numbers = '{31'd0, 31'd1, 31'd9, 31'd10, 31'd99, 31'd100,
                        31'd999999999, 31'd1000000000, 31'h7FFFFFFF};
    radix_seen[rdc_pkg::RADIX_RESET] = 1'b1;

    // Base two gives the longest digit runs.
    set_radix(6'd2);
    @(negedge clk);
    pending_numbers = '{31'd0, 31'd1, 31'h7FFFFFFF, 31'h40000000};

    // Base thirty-six reaches the letter Z.
    set_radix(6'd36);
    @(negedge clk);
    pending_numbers = '{31'd35, 31'd36, 31'd1295, 31'h7FFFFFFF};

    // Register values below two and above thirty-six saturate.
    set_radix(6'd0);
    @(negedge clk);
    pending_numbers.push_back(31'd5);
    set_radix(6'd1);
    @(negedge clk);
    pending_numbers.push_back(31'd6);
    set_radix(6'd37);
    @(negedge clk);
    pending_numbers.push_back(31'd1295);
    set_radix(6'd63);
    @(negedge clk);
    pending_numbers.push_back(31'd46655);

    set_radix(6'd16);
    @(negedge clk);
    pending_numbers = '{31'h7ABCDEF0, 31'h12345678};

    run_random(1'b0, 1'b0);

    wait_idle();
    @(negedge clk);
    send_idle_pct = 67;
    recv_idle_pct = 12;
    run_random(1'b1, 1'b0);

    wait_idle();
    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(1'b0, 1'b1);

    // Everything is out. A few more cycles catch any stray digit.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_digits.size() != 0) begin
      flag_error($sformatf("%0d digits never arrived", expected_digits.size()));
    end

    $display("Converted %0d numbers into %0d checked digits over %0d base settings,",
             numbers_sent, digits_checked, $countones(radix_seen));
    $display("longest run %0d digits, input held off by full for %0d cycles, %0d errors.",
             longest_run, full_stalls, error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: stops a hung run and reports a failure.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
